// File: hdl/slp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak limiter package
// Shared types, fixed-point constants, sequencer states and the output
// rounding function.
// ----------------------------------------------------------------------------
package slp_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int PEAK_W    = 23;
    localparam int GAIN_W    = 21;
    localparam int COEFF_W   = 24;
    localparam int QUOT_W    = 20;
    localparam int DIV_STEPS = QUOT_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [GAIN_W-1:0]  ONE_Q20       = 21'h100000;
    localparam logic [PEAK_W-1:0]  ENV_MAX       = 23'h7FFFFF;
    localparam logic [COEFF_W-1:0] ATTACK_RESET  = 24'd16431305;
    localparam logic [COEFF_W-1:0] RELEASE_RESET = 24'd16770227;
    // ceil(2^27 / 10): floor(n / 10) == (n * RECIP10) >> 27 for n below 2^26.
    localparam logic [23:0]        RECIP10       = 24'd13421773;

    // Configuration register indexes.
    localparam logic CFG_ATTACK  = 1'b0;
    localparam logic CFG_RELEASE = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic        [PEAK_W-1:0]   peak;
        logic                       last;
    } frame_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_ACC,
        S_DIV,
        S_SUM,
        S_MUL10,
        S_GAIN,
        S_MUL_L,
        S_MUL_R,
        S_PUSH
    } lim_state_t;

    // Round a Q4.20 x Q1.20 product back to Q4.20 (floor after adding one
    // half) and clamp to the sample range.
    function automatic logic signed [SAMPLE_W-1:0] round_q20(
        input logic signed [45:0] p
    );
        logic signed [45:0] t;
        logic signed [25:0] s;
        logic signed [SAMPLE_W-1:0] r;
        t = p + 46'sd524288;
        s = t[45:20];
        if (s > 26'sd8388607)
        begin
            r = 24'sh7FFFFF;
        end
        else if (s < -26'sd8388608)
        begin
            r = 24'sh800000;
        end
        else
        begin
            r = s[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/stereo_peak_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak limiter
// Peak envelope follower with smoothed 1/envelope gain applied to a stereo
// Q4.20 stream; attack and release weights are writable registers.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Word
//  input     in_valid / in_stall        left_in, right_in, block_end
//  output    out_valid / out_stall      left_out, right_out, applied_gain,
//                                       frame_last
//  config    cfg_we (no wait)           cfg_index, cfg_data
//
//  A frame skips the divider when the envelope is at or below unity; when it
//  is above, a 20-step restoring divider forms the reciprocal; that sequencer
//  sets the throughput.
//  The front end and a two-word queue keep accepting frames, until the queue
//  is full, while the engine works or the output word is stalled.
//  Reset clears the envelope, sets the gain to unity and loads the default
//  weights; no clearing pass is needed.
// ----------------------------------------------------------------------------
module stereo_peak_limiter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [23:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [23:0]  left_in,
    input  logic signed [23:0]  right_in,
    input  logic                block_end,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [23:0]  left_out,
    output logic signed [23:0]  right_out,
    output logic [20:0]         applied_gain,
    output logic                frame_last
);
    import slp_pkg::*;

    logic [COEFF_W-1:0] attack_reg;
    logic [COEFF_W-1:0] release_reg;
    logic               push_valid;
    logic               push_ready;
    frame_t             push_frame;
    logic               pop_valid;
    logic               pop;
    frame_t             pop_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= ATTACK_RESET;
            release_reg <= RELEASE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ATTACK:  attack_reg  <= cfg_data;
                CFG_RELEASE: release_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    slp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .left_in    (left_in),
        .right_in   (right_in),
        .block_end  (block_end),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_frame (push_frame)
    );

    slp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_frame (push_frame),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_frame  (pop_frame)
    );

    slp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .attack_coeff  (attack_reg),
        .release_coeff (release_reg),
        .pop_valid     (pop_valid),
        .pop           (pop),
        .pop_frame     (pop_frame),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .left_out      (left_out),
        .right_out     (right_out),
        .applied_gain  (applied_gain),
        .frame_last    (frame_last)
    );

endmodule

// File: hdl/slp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak limiter front end
// Accepts input words, forms the saturated frame peak and holds the
// frame until the queue takes it.
// ----------------------------------------------------------------------------
module slp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [23:0]            left_in,
    input  logic signed [23:0]            right_in,
    input  logic                          block_end,
    output logic                          push_valid,
    input  logic                          push_ready,
    output slp_pkg::frame_t               push_frame
);
    import slp_pkg::*;

    logic         fv_reg;
    logic         fv_next;
    frame_t       frame_reg;
    logic [23:0]  mag_l;
    logic [23:0]  mag_r;
    logic [PEAK_W-1:0] sat_l;
    logic [PEAK_W-1:0] sat_r;
    logic         take;

    always_comb
    begin
        mag_l = left_in[23] ? (~left_in + 24'd1) : left_in;
        mag_r = right_in[23] ? (~right_in + 24'd1) : right_in;
        // Only the most negative sample reaches bit 23; it saturates.
        sat_l = mag_l[23] ? ENV_MAX : mag_l[PEAK_W-1:0];
        sat_r = mag_r[23] ? ENV_MAX : mag_r[PEAK_W-1:0];
    end

    assign in_stall   = fv_reg && !push_ready;
    assign take       = in_valid && !in_stall;
    assign fv_next    = take || (fv_reg && !push_ready);
    assign push_valid = fv_reg;
    assign push_frame = frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            frame_reg.left  <= left_in;
            frame_reg.right <= right_in;
            frame_reg.peak  <= (sat_l > sat_r) ? sat_l : sat_r;
            frame_reg.last  <= block_end;
        end
    end

endmodule

// File: hdl/slp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak limiter frame queue
// Short first-in first-out buffer between the front end and the gain engine.
// ----------------------------------------------------------------------------
module slp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  slp_pkg::frame_t  push_frame,
    output logic             pop_valid,
    input  logic             pop,
    output slp_pkg::frame_t  pop_frame
);
    import slp_pkg::*;

    frame_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_frame  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_frame;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count out of range");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("pop requested from an empty queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with an empty count");

endmodule

// File: hdl/slp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak limiter gain engine
// Sequencer that updates the envelope, forms the target gain (with a serial
// reciprocal when the envelope is above unity), smooths the gain and scales
// both channels into the output register.
// ----------------------------------------------------------------------------
module slp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [23:0]             attack_coeff,
    input  logic [23:0]             release_coeff,
    input  logic                    pop_valid,
    output logic                    pop,
    input  slp_pkg::frame_t         pop_frame,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [23:0]      left_out,
    output logic signed [23:0]      right_out,
    output logic [20:0]             applied_gain,
    output logic                    frame_last
);
    import slp_pkg::*;

    lim_state_t                 state_reg;
    lim_state_t                 state_next;
    frame_t                     frame_reg;
    logic [PEAK_W-1:0]          env_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic [COEFF_W-1:0]         coeff_reg;
    logic [47:0]                prod_a_reg;
    logic [46:0]                prod_b_reg;
    logic [23:0]                rem_reg;
    logic [QUOT_W-1:0]          quo_reg;
    logic [DCNT_W-1:0]          cnt_reg;
    logic [GAIN_W-1:0]          target_reg;
    logic [23:0]                sum_reg;
    logic [47:0]                prod10_reg;
    logic signed [45:0]         prod_s_reg;
    logic signed [SAMPLE_W-1:0] left_res_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] left_out_reg;
    logic signed [SAMPLE_W-1:0] right_out_reg;
    logic [GAIN_W-1:0]          gain_out_reg;
    logic                       last_out_reg;

    logic [24:0]                coeff_inv;
    logic [48:0]                acc;
    logic [24:0]                env_raw;
    logic [PEAK_W-1:0]          env_new;
    logic                       env_big;
    logic [23:0]                rem_shift;
    logic                       rem_ge;
    logic [QUOT_W-1:0]          quo_next;
    logic                       div_last;
    logic [GAIN_W-1:0]          gain_q;
    logic                       out_load;

    always_comb
    begin
        coeff_inv = 25'h1000000 - {1'b0, coeff_reg};
        acc       = {1'b0, prod_a_reg} + {2'b00, prod_b_reg} + 49'h800000;
        env_raw   = acc[48:24];
        env_new   = (env_raw > {2'b00, ENV_MAX}) ? ENV_MAX : env_raw[PEAK_W-1:0];
        env_big   = (env_new > {2'b00, ONE_Q20});
        rem_shift = {rem_reg[22:0], 1'b0};
        rem_ge    = (rem_shift >= {1'b0, env_reg});
        quo_next  = {quo_reg[QUOT_W-2:0], rem_ge};
        div_last  = (cnt_reg == DCNT_W'(DIV_STEPS - 1));
        gain_q    = (prod10_reg[47:27] > ONE_Q20) ? ONE_Q20 : prod10_reg[47:27];
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = S_MUL_A;
                end
            end
            S_MUL_A: state_next = S_MUL_B;
            S_MUL_B: state_next = S_ACC;
            S_ACC:   state_next = env_big ? S_DIV : S_SUM;
            S_DIV:
            begin
                if (div_last)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:   state_next = S_MUL10;
            S_MUL10: state_next = S_GAIN;
            S_GAIN:  state_next = S_MUL_L;
            S_MUL_L: state_next = S_MUL_R;
            S_MUL_R: state_next = S_PUSH;
            S_PUSH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        pop      = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            S_IDLE: pop      = pop_valid;
            S_PUSH: out_load = !out_valid_reg || !out_stall;
            default:
            begin
                pop      = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            env_reg       <= '0;
            gain_reg      <= ONE_Q20;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_ACC)
            begin
                env_reg <= env_new;
            end
            if (state_reg == S_GAIN)
            begin
                gain_reg <= gain_q;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                frame_reg <= pop_frame;
                coeff_reg <= (pop_frame.peak > env_reg) ? attack_coeff : release_coeff;
            end
            S_MUL_A: prod_a_reg <= 48'(frame_reg.peak) * 48'(coeff_inv);
            S_MUL_B: prod_b_reg <= 47'(env_reg) * 47'(coeff_reg);
            S_ACC:
            begin
                // Division starts with 2^40 >> 20 already brought down.
                rem_reg    <= 24'(ONE_Q20);
                quo_reg    <= '0;
                cnt_reg    <= '0;
                target_reg <= ONE_Q20;
            end
            S_DIV:
            begin
                rem_reg <= rem_ge ? (rem_shift - {1'b0, env_reg}) : rem_shift;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (div_last)
                begin
                    target_reg <= {1'b0, quo_next};
                end
            end
            S_SUM:
            begin
                sum_reg <= {gain_reg, 3'b000} + 24'(gain_reg) + 24'(target_reg) + 24'd5;
            end
            S_MUL10: prod10_reg <= 48'(sum_reg) * 48'(RECIP10);
            S_MUL_L: prod_s_reg <= 46'(frame_reg.left) * 46'($signed({1'b0, gain_reg}));
            S_MUL_R:
            begin
                left_res_reg <= round_q20(prod_s_reg);
                prod_s_reg   <= 46'(frame_reg.right) * 46'($signed({1'b0, gain_reg}));
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            left_out_reg  <= left_res_reg;
            right_out_reg <= round_q20(prod_s_reg);
            gain_out_reg  <= gain_reg;
            last_out_reg  <= frame_reg.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign left_out     = left_out_reg;
    assign right_out    = right_out_reg;
    assign applied_gain = gain_out_reg;
    assign frame_last   = last_out_reg;

    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (gain_out_reg <= ONE_Q20))
        else $error("applied gain above unity");

    a_div_operand: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (env_reg > {2'b00, ONE_Q20}))
        else $error("reciprocal started on an envelope at or below unity");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < {1'b0, env_reg}))
        else $error("reciprocal remainder not below divisor");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten while held");

endmodule

// File: tb/sv/slp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak limiter checker
// Watches the register port and both word channels, keeps its own envelope,
// gain and weight state, predicts every limited frame and compares it with
// the words that leave the block, in order.
// ----------------------------------------------------------------------------
module slp_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [23:0] left_in,
    input  logic signed [23:0] right_in,
    input  logic               block_end,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [23:0] left_out,
    input  logic signed [23:0] right_out,
    input  logic [20:0]        applied_gain,
    input  logic               frame_last,
    output int                 fail_count,
    output int                 pending
);
    import slp_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic        [GAIN_W-1:0]   gain;
        logic                       last;
    } limited_frame_t;

    localparam longint FULL_ONE  = 64'sd1048576;
    localparam longint PEAK_LIM  = 64'sd8388607;
    localparam longint SAMPLE_LO = -64'sd8388608;

    logic [COEFF_W-1:0] attack_w;
    logic [COEFF_W-1:0] release_w;
    logic [PEAK_W-1:0]  envelope;
    logic [GAIN_W-1:0]  gain;
    limited_frame_t     limited_frames[$];

    function automatic logic signed [SAMPLE_W-1:0] scale_sample(
        input logic signed [SAMPLE_W-1:0] s,
        input logic [GAIN_W-1:0] g
    );
        longint sv;
        longint gv;
        longint p;
        sv = s;
        gv = g;
        // An arithmetic shift floors, which matches rounding by adding a half.
        p = (sv * gv + 64'sd524288) >>> 20;
        if (p > PEAK_LIM)
        begin
            p = PEAK_LIM;
        end
        if (p < SAMPLE_LO)
        begin
            p = SAMPLE_LO;
        end
        return p[SAMPLE_W-1:0];
    endfunction

    task automatic limit_frame(
        input logic signed [SAMPLE_W-1:0] l,
        input logic signed [SAMPLE_W-1:0] r,
        input logic last
    );
        longint lv;
        longint rv;
        longint peak;
        longint c;
        longint env;
        longint old_env;
        longint target;
        longint g;
        limited_frame_t f;
        lv = l;
        rv = r;
        lv = (lv < 0) ? -lv : lv;
        rv = (rv < 0) ? -rv : rv;
        peak = (lv > rv) ? lv : rv;
        if (peak > PEAK_LIM)
        begin
            peak = PEAK_LIM;
        end
        old_env = envelope;
        c = (peak > old_env) ? longint'(attack_w) : longint'(release_w);
        env = (peak * (64'sd16777216 - c) + old_env * c + 64'sd8388608) >>> 24;
        if (env > PEAK_LIM)
        begin
            env = PEAK_LIM;
        end
        target = (env > FULL_ONE) ? ((64'sd1 <<< 40) / env) : FULL_ONE;
        g = gain;
        g = (9 * g + target + 5) / 10;
        if (g > FULL_ONE)
        begin
            g = FULL_ONE;
        end
        envelope = env[PEAK_W-1:0];
        gain = g[GAIN_W-1:0];
        f.left = scale_sample(l, gain);
        f.right = scale_sample(r, gain);
        f.gain = gain;
        f.last = last;
        limited_frames.insert(limited_frames.size(), f);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        limited_frame_t want;
        if (!rst_n)
        begin
            attack_w = ATTACK_RESET;
            release_w = RELEASE_RESET;
            envelope = '0;
            gain = ONE_Q20;
            limited_frames.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ATTACK:  attack_w = cfg_data;
                    CFG_RELEASE: release_w = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
            begin
                limit_frame(left_in, right_in, block_end);
            end
            if (out_valid && !out_stall)
            begin
                if (limited_frames.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("%0t: output word with no frame pending:", $realtime);
                        $display("%0t:   l=%0d r=%0d g=%0d last=%0b",
                                 $realtime, left_out, right_out, applied_gain, frame_last);
                    end
                    fail_count++;
                end
                else
                begin
                    want = limited_frames.pop_front();
                    if (left_out !== want.left || right_out !== want.right ||
                        applied_gain !== want.gain || frame_last !== want.last)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: mismatch: expected l=%0d r=%0d g=%0d last=%0b",
                                     $realtime, want.left, want.right, want.gain,
                                     want.last);
                            $display("%0t:           actual   l=%0d r=%0d g=%0d last=%0b",
                                     $realtime, left_out, right_out, applied_gain,
                                     frame_last);
                        end
                        fail_count++;
                    end
                end
            end
            pending <= limited_frames.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak limiter testbench
// Drives directed and random stereo frames through the limiter under
// several attack and release weights, with bursty input and a stalling
// receiver; the checker predicts each output word and reports failures.
// ----------------------------------------------------------------------------
module tb;
    import slp_pkg::*;

    localparam int RAND_ITEMS     = 1850;
    localparam int N_PHASES       = 6;
    localparam int WATCHDOG_LIMIT = 5000;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [23:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [23:0] left_in;
    logic signed [23:0] right_in;
    logic               block_end;
    logic               out_valid;
    logic               out_stall;
    logic signed [23:0] left_out;
    logic signed [23:0] right_out;
    logic [20:0]        applied_gain;
    logic               frame_last;
    int                 fail_count;
    int                 pending;
    int                 burst_left = 0;
    int                 idle_cycles = 0;

    stereo_peak_limiter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .left_in      (left_in),
        .right_in     (right_in),
        .block_end    (block_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_out     (left_out),
        .right_out    (right_out),
        .applied_gain (applied_gain),
        .frame_last   (frame_last)
    );

    slp_checker limiter_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .left_in      (left_in),
        .right_in     (right_in),
        .block_end    (block_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_out     (left_out),
        .right_out    (right_out),
        .applied_gain (applied_gain),
        .frame_last   (frame_last),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("FAIL stereo_peak_limiter");
                $finish;
            end
        end
    end

    // The receiver runs its own stall pattern, switching style every so often.
    initial
    begin : receiver
        int mode;
        int run;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            run = $urandom_range(8, 80);
            for (int i = 0; i < run; i++)
            begin
                @(posedge clk);
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= 1'($urandom_range(0, 1));
                    2:       out_stall <= (i < run / 2);
                    default: out_stall <= ((i % 4) == 3);
                endcase
            end
        end
    end

    function automatic logic signed [23:0] pick_sample(input int amp);
        int v;
        case ($urandom_range(0, 11))
            0:
            begin
                v = $urandom();
                return v[23:0];
            end
            1:       return 24'sh800000;
            2:       return 24'sh7FFFFF;
            default:
            begin
                v = $urandom_range(0, 2 * amp) - amp;
                return v[23:0];
            end
        endcase
    endfunction

    task automatic send_frame(
        input logic signed [23:0] l,
        input logic signed [23:0] r,
        input logic last
    );
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
        end
        burst_left--;
        left_in <= l;
        right_in <= r;
        block_end <= last;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Waits until every frame sent so far has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Called only when the block is idle, just after the clock rises.
    task automatic set_weights(input logic [23:0] attack, input logic [23:0] rel);
        cfg_we <= 1'b1;
        cfg_index <= CFG_ATTACK;
        cfg_data <= attack;
        @(posedge clk);
        cfg_index <= CFG_RELEASE;
        cfg_data <= rel;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [23:0] attack_set[N_PHASES];
        logic [23:0] release_set[N_PHASES];
        int amp;
        int seg_left;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_ATTACK;
        cfg_data <= '0;
        in_valid <= 1'b0;
        left_in <= '0;
        right_in <= '0;
        block_end <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default weights: field extremes, then a loud run that pushes the
        // envelope above unity so the reciprocal path is taken.
        send_frame(24'sd0, 24'sd0, 1'b0);
        send_frame(24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
        send_frame(24'sh800000, 24'sh800000, 1'b0);
        send_frame(24'sh7FFFFF, 24'sh800000, 1'b1);
        send_frame(24'sd1048576, -24'sd1048576, 1'b0);
        send_frame(24'sd1048577, 24'sd0, 1'b0);
        send_frame(-24'sd1, 24'sd1, 1'b1);
        for (int i = 0; i < 6; i++)
        begin
            send_frame(24'sh800000, 24'sh7FFFFF, i[0]);
        end
        send_frame(24'sd1000, -24'sd1000, 1'b0);
        drain();

        // Zero weights: the envelope jumps straight to each peak.
        set_weights(24'd0, 24'd0);
        send_frame(24'sd4194304, 24'sd0, 1'b0);
        send_frame(24'sd0, -24'sd2097152, 1'b1);
        send_frame(24'sd0, 24'sd0, 1'b0);
        send_frame(24'sh7FFFFF, 24'sh800000, 1'b0);
        send_frame(24'sd524288, 24'sd1048577, 1'b1);
        drain();

        attack_set[0] = 24'hFFFFFF;
        release_set[0] = 24'hFFFFFF;
        attack_set[1] = 24'h000000;
        release_set[1] = 24'hFFFFFF;
        attack_set[2] = ATTACK_RESET;
        release_set[2] = RELEASE_RESET;
        attack_set[3] = 24'($urandom());
        release_set[3] = 24'($urandom());
        attack_set[4] = 24'($urandom_range(0, 24'h7FFFFF));
        release_set[4] = 24'($urandom_range(24'h800000, 24'hFFFFFF));
        attack_set[5] = 24'hFFFFFF;
        release_set[5] = 24'h000000;

        amp = 8388607;
        seg_left = 0;
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            set_weights(attack_set[ph], release_set[ph]);
            for (int n = 0; n < RAND_ITEMS / N_PHASES; n++)
            begin
                // Loudness changes in segments so the envelope has time to
                // rise above unity and fall back.
                if (seg_left == 0)
                begin
                    case ($urandom_range(0, 4))
                        0:       amp = 65536;
                        1:       amp = 1048576;
                        2:       amp = 1572864;
                        3:       amp = 4194304;
                        default: amp = 8388607;
                    endcase
                    seg_left = $urandom_range(20, 200);
                end
                seg_left--;
                send_frame(pick_sample(amp), pick_sample(amp), $urandom_range(0, 15) == 0);
            end
            drain();
        end

        repeat (40) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("PASS stereo_peak_limiter");
        end
        else
        begin
            $display("FAIL stereo_peak_limiter");
        end
        $finish;
    end

endmodule
